FILE: rtl/core/fdc_rw_pkg.sv
// Shared types, constants and the status decode of the floppy command and status block.
package fdc_rw_pkg;

  localparam int ADDR_W_DEF  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_BITS    = 4;
  localparam int CAUSE_W     = 14;

  localparam logic [7:0] OPC_READ  = 8'hC6;
  localparam logic [7:0] OPC_WRITE = 8'hC5;
  localparam logic [7:0] SIZE_512  = 8'h02;
  localparam logic [7:0] DATA_LEN  = 8'hFF;

  localparam logic [5:0] SPT_RST = 6'd18;
  localparam logic [1:0] HC_RST  = 2'd2;
  localparam logic [7:0] EOT_RST = 8'd18;
  localparam logic [7:0] GAP_RST = 8'd27;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SPT = 2'd0;
  localparam logic [1:0] REG_HC  = 2'd1;
  localparam logic [1:0] REG_EOT = 2'd2;
  localparam logic [1:0] REG_GAP = 2'd3;

  // Positions of the nine command bytes.
  localparam logic [3:0] POS_OPC   = 4'd0;
  localparam logic [3:0] POS_HDS   = 4'd1;
  localparam logic [3:0] POS_CYL   = 4'd2;
  localparam logic [3:0] POS_HEAD  = 4'd3;
  localparam logic [3:0] POS_SEC   = 4'd4;
  localparam logic [3:0] POS_SIZE  = 4'd5;
  localparam logic [3:0] POS_EOT   = 4'd6;
  localparam logic [3:0] POS_GAP   = 4'd7;
  localparam logic [3:0] POS_DTL   = 4'd8;

  typedef struct packed {
    logic [5:0] spt;
    logic [1:0] hc;
    logic [7:0] eot;
    logic [7:0] gap;
  } fdc_cfg_t;

  typedef struct packed {
    logic               is_check;
    logic               range_err;
    logic               write_dir;
    logic [1:0]         head;
    logic [7:0]         cyl;
    logic [7:0]         sec;
    logic [CAUSE_W-1:0] causes;
  } fdc_desc_t;

  function automatic logic [CAUSE_W-1:0] decode_causes(input logic [7:0] st0,
                                                       input logic [7:0] st1,
                                                       input logic [7:0] st2,
                                                       input logic [7:0] size);
    logic [CAUSE_W-1:0] c;
    c[0]  = |(st0 & 8'hC0);
    c[1]  = |(st0 & 8'h08);
    c[2]  = |(st1 & 8'h80);
    c[3]  = |(st1 & 8'h20);
    c[4]  = |(st1 & 8'h10);
    c[5]  = |(st1 & 8'h04);
    c[6]  = |(st1 & 8'h02);
    c[7]  = |((st1 | st2) & 8'h01);
    c[8]  = |(st2 & 8'h40);
    c[9]  = |(st2 & 8'h20);
    c[10] = |(st2 & 8'h10);
    c[11] = |(st2 & 8'h04);
    c[12] = |(st2 & 8'h02);
    c[13] = (size != SIZE_512);
    return c;
  endfunction

endpackage

FILE: rtl/core/fdc_rw_ifs.sv
// Valid/ready channel interfaces for the request and result streams.
interface fdc_in_if #(
  parameter int ADDRESS_WIDTH = fdc_rw_pkg::ADDR_W_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ADDRESS_WIDTH-1:0] block_address;
  logic                     write_dir;
  logic [7:0]               status_zero;
  logic [7:0]               status_one;
  logic [7:0]               status_two;
  logic [7:0]               size_code;

  modport source (output valid, func, block_address, write_dir, status_zero, status_one,
                  status_two, size_code, input ready);
  modport sink (input valid, func, block_address, write_dir, status_zero, status_one,
                status_two, size_code, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cmd_byte;
  logic        last;
  logic        range_error;
  logic        status_error;
  logic [13:0] error_causes;

  modport source (output valid, cmd_byte, last, range_error, status_error, error_causes,
                  input ready);
  modport sink (input valid, cmd_byte, last, range_error, status_error, error_causes,
                output ready);
endinterface

FILE: rtl/core/fdc_rw_front.sv
// Front end: accept items, decode status, convert block address to cylinder/head/sector.
module fdc_rw_front #(
  parameter int ADDRESS_WIDTH = fdc_rw_pkg::ADDR_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fdc_in_if.sink                in_chan,
  input  fdc_rw_pkg::fdc_cfg_t  cfg,
  output fdc_rw_pkg::fdc_desc_t desc,
  output logic                  desc_valid,
  input  logic                  desc_ready
);
  import fdc_rw_pkg::*;

  localparam int DIV_STEPS = (ADDRESS_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  logic               busy_r;
  logic [STEP_W-1:0]  steps_r;
  logic               is_check_r;
  logic               wr_r;
  logic [DIV_W-1:0]   dvd_r;
  logic [5:0]         rem_r;
  logic [1:0]         hrem_r;
  logic [DIV_W-1:0]   cyl_r;
  logic [CAUSE_W-1:0] causes_r;

  logic [DIV_W-1:0]   dvd_nxt;
  logic [5:0]         rem_nxt;
  logic [1:0]         hrem_nxt;
  logic [DIV_W-1:0]   cyl_nxt;
  logic [6:0]         rem_w;
  logic [2:0]         h_w;
  logic               qbit;
  logic               cbit;
  logic [5:0]         spt_eff;
  logic [1:0]         hc_eff;
  logic               done;
  logic               accept;

  assign spt_eff = (cfg.spt == 6'd0) ? 6'd1 : cfg.spt;
  assign hc_eff  = (cfg.hc == 2'd0) ? 2'd1 : cfg.hc;

  // One iteration: DIV_BITS quotient bits of address/spt, each fed straight
  // into the track/head_count remainder chain.
  always_comb begin
    rem_nxt  = rem_r;
    hrem_nxt = hrem_r;
    cyl_nxt  = cyl_r;
    rem_w    = '0;
    h_w      = '0;
    qbit     = 1'b0;
    cbit     = 1'b0;
    for (int j = 0; j < DIV_BITS; j++) begin
      rem_w = {rem_nxt, dvd_r[DIV_W-1-j]};
      qbit  = (rem_w >= {1'b0, spt_eff});
      if (qbit) begin
        rem_w = rem_w - {1'b0, spt_eff};
      end
      rem_nxt = rem_w[5:0];
      h_w     = {hrem_nxt, qbit};
      cbit    = (h_w >= {1'b0, hc_eff});
      if (cbit) begin
        h_w = h_w - {1'b0, hc_eff};
      end
      hrem_nxt = h_w[1:0];
      cyl_nxt  = {cyl_nxt[DIV_W-2:0], cbit};
    end
    dvd_nxt = dvd_r << DIV_BITS;
  end

  assign done           = busy_r && (steps_r == '0);
  assign in_chan.ready  = !busy_r || (done && desc_ready);
  assign accept         = in_chan.valid && in_chan.ready;
  assign desc_valid     = done;

  assign desc.is_check  = is_check_r;
  assign desc.range_err = !is_check_r && (|cyl_r[DIV_W-1:8]);
  assign desc.write_dir = wr_r;
  assign desc.head      = hrem_r;
  assign desc.cyl       = cyl_r[7:0];
  assign desc.sec       = {2'b00, rem_r} + 8'd1;
  assign desc.causes    = causes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      steps_r <= '0;
    end else if (accept) begin
      busy_r  <= 1'b1;
      steps_r <= in_chan.func ? '0 : STEP_W'(DIV_STEPS);
    end else if (busy_r && (steps_r != '0)) begin
      steps_r <= steps_r - 1'b1;
    end else if (done && desc_ready) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_check_r <= in_chan.func;
      wr_r       <= in_chan.write_dir;
      dvd_r      <= DIV_W'(in_chan.block_address[ADDRESS_WIDTH-1:0]);
      rem_r      <= '0;
      hrem_r     <= '0;
      cyl_r      <= '0;
      causes_r   <= decode_causes(in_chan.status_zero, in_chan.status_one,
                                  in_chan.status_two, in_chan.size_code);
    end else if (busy_r && (steps_r != '0)) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      hrem_r <= hrem_nxt;
      cyl_r  <= cyl_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("front not busy after accepting a transaction");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    done && !desc_ready |=> done && $stable(desc))
    else $error("front descriptor changed while the queue was full");

endmodule

FILE: rtl/core/fdc_rw_queue.sv
// Short descriptor queue between the front end and the byte sequencer.
module fdc_rw_queue #(
  parameter int DEPTH = fdc_rw_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdc_rw_pkg::fdc_desc_t push_desc,
  input  logic                  push,
  output logic                  push_ready,
  output fdc_rw_pkg::fdc_desc_t pop_desc,
  output logic                  pop_valid,
  input  logic                  pop
);
  import fdc_rw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fdc_desc_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push && !push_ready |=> push && $stable(push_desc))
    else $error("push dropped or changed while the queue was full");

endmodule

FILE: rtl/core/fdc_rw_back.sv
// Back end: step through the command bytes of each descriptor into the output register.
module fdc_rw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fdc_rw_pkg::fdc_desc_t desc,
  input  logic                  desc_valid,
  output logic                  desc_pop,
  input  fdc_rw_pkg::fdc_cfg_t  cfg,
  fdc_out_if.source             out_chan
);
  import fdc_rw_pkg::*;

  logic [3:0]         idx_r;
  logic               out_valid_r;
  logic [7:0]         byte_r;
  logic               last_r;
  logic               rerr_r;
  logic               serr_r;
  logic [CAUSE_W-1:0] causes_r;

  logic               step;
  logic               single;
  logic               last_c;
  logic [7:0]         byte_c;

  assign step     = desc_valid && (!out_valid_r || out_chan.ready);
  assign single   = desc.is_check || desc.range_err;
  assign last_c   = single || (idx_r == POS_DTL);
  assign desc_pop = step && last_c;

  always_comb begin
    byte_c = 8'h00;
    if (!single) begin
      unique case (idx_r)
        POS_OPC:  byte_c = desc.write_dir ? OPC_WRITE : OPC_READ;
        POS_HDS:  byte_c = {4'b0000, desc.head, 2'b00};
        POS_CYL:  byte_c = desc.cyl;
        POS_HEAD: byte_c = {6'b000000, desc.head};
        POS_SEC:  byte_c = desc.sec;
        POS_SIZE: byte_c = SIZE_512;
        POS_EOT:  byte_c = cfg.eot;
        POS_GAP:  byte_c = cfg.gap;
        POS_DTL:  byte_c = DATA_LEN;
        default:  byte_c = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= POS_OPC;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        idx_r <= last_c ? POS_OPC : idx_r + 4'd1;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r   <= byte_c;
      last_r   <= last_c;
      rerr_r   <= desc.range_err && !desc.is_check;
      serr_r   <= desc.is_check && (|desc.causes);
      causes_r <= desc.is_check ? desc.causes : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.cmd_byte     = byte_r;
  assign out_chan.last         = last_r;
  assign out_chan.range_error  = rerr_r;
  assign out_chan.status_error = serr_r;
  assign out_chan.error_causes = causes_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= POS_DTL)
    else $error("command byte index past the data length byte");

  a_rerr_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rerr_r |-> last_r && (byte_r == 8'h00) && !serr_r)
    else $error("range error result is not a lone empty transaction");

endmodule

FILE: rtl/core/floppy_rw_command_and_status_top.sv
// Top level of the floppy read/write command builder and status checker.
//
// in_chan  : request transactions. func = 0 issues a READ DATA / WRITE DATA command
//            for block_address; func = 1 checks three status bytes and the size code.
// out_chan : result transactions. An issue request yields nine command bytes (last on
//            the ninth), or one transaction with range_error when the cylinder exceeds
//            255. A check request yields one transaction carrying error_causes and
//            status_error.
// cfg_*    : register writes (sectors per track, head count, end of track, gap
//            length); write only while the block is idle.
// Order: a check request skips the address division; an issue request runs it first,
//   then shows its command bytes one per cycle while out_chan is ready.
// Throughput: issue requests are bounded by the byte sequencer, nine bytes each;
//   check requests go at one per cycle while nothing stalls; range-error requests
//   are bounded by the address division (4 quotient bits a cycle), which overlaps
//   the previous command's byte output; the front end takes no request meanwhile.
// Reset: synchronous, active low; registers return to 18/2/18/27 and all queued work
//   is dropped. A stalled out_chan holds its transaction; the queue then fills and
//   in_chan.ready drops.
module floppy_rw_command_and_status_top #(
  parameter int ADDRESS_WIDTH = fdc_rw_pkg::ADDR_W_DEF,
  parameter int QUEUE_DEPTH   = fdc_rw_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  fdc_in_if.sink     in_chan,
  fdc_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import fdc_rw_pkg::*;

  // Configuration registers; live values feed both halves.
  fdc_cfg_t  cfg_r;

  // Descriptor hand-off: front -> queue -> back.
  fdc_desc_t front_desc;
  logic      front_valid;
  logic      queue_ready;
  fdc_desc_t back_desc;
  logic      back_valid;
  logic      back_pop;

  // Write one register per enabled cycle; unused high bits drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spt <= SPT_RST;
      cfg_r.hc  <= HC_RST;
      cfg_r.eot <= EOT_RST;
      cfg_r.gap <= GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPT: cfg_r.spt <= cfg_wdata[5:0];
        REG_HC:  cfg_r.hc  <= cfg_wdata[1:0];
        REG_EOT: cfg_r.eot <= cfg_wdata;
        REG_GAP: cfg_r.gap <= cfg_wdata;
      endcase
    end
  end

  // Accept and classify; runs the address division.
  fdc_rw_front #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .desc       (front_desc),
    .desc_valid (front_valid),
    .desc_ready (queue_ready)
  );

  // Decouple the division from the byte stream.
  fdc_rw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_desc  (front_desc),
    .push       (front_valid),
    .push_ready (queue_ready),
    .pop_desc   (back_desc),
    .pop_valid  (back_valid),
    .pop        (back_pop)
  );

  // Sequence the command bytes into the output register.
  fdc_rw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (back_desc),
    .desc_valid (back_valid),
    .desc_pop   (back_pop),
    .cfg        (cfg_r),
    .out_chan   (out_chan)
  );

endmodule
